// File: sv/bmd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the BLE-MIDI packet deframer.
// No dependencies; compiled first.
package bmd_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 10;

   localparam int PACKET_CAPACITY_DEFAULT = 64;

   localparam int TOP_BIT = BYTE_W - 1;
   localparam logic [BYTE_W-1:0] SYSEX_START = 8'hF0;
   localparam logic [BYTE_W-1:0] SYSEX_END   = 8'hF7;

   // position within the open packet
   localparam logic [1:0] POS_IDLE   = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_LATER  = 2'd2;

   typedef struct packed {
      logic [1:0] byte_position;
      logic       timestamp_may_follow;
      logic       in_sysex;
      logic       dropping_packet;
   } state_type;

endpackage

// File: sv/bmd_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the deframer: packet bytes in, MIDI bytes out.
// Depends on bmd_pkg.
interface bmd_req_if;
   import bmd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] packet_byte;
   logic              starts_packet;
   logic [LEN_W-1:0]  packet_length;

   modport source (output valid, packet_byte, starts_packet, packet_length, input ready);
   modport sink   (input valid, packet_byte, starts_packet, packet_length, output ready);
endinterface

interface bmd_rsp_if;
   import bmd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] midi_byte;

   modport source (output valid, midi_byte, input ready);
   modport sink   (input valid, midi_byte, output ready);
endinterface

// File: sv/bmd_deframe_core.sv
`timescale 1ns / 1ps
// Per-byte decision logic: next deframer state and whether the byte is passed on.
// Depends on bmd_pkg.
module bmd_deframe_core #(
   parameter int PACKET_CAPACITY = bmd_pkg::PACKET_CAPACITY_DEFAULT
) (
   input  bmd_pkg::state_type               state,
   input  logic [bmd_pkg::BYTE_W-1:0]       packet_byte,
   input  logic                             starts_packet,
   input  logic [bmd_pkg::LEN_W-1:0]        packet_length,
   output bmd_pkg::state_type               state_next,
   output logic                             emit
);
   import bmd_pkg::*;

   localparam logic [LEN_W:0] CAPACITY = (LEN_W+1)'(PACKET_CAPACITY);

   logic top_set;
   logic sysex_next;

   assign top_set = packet_byte[TOP_BIT];

   always_comb begin
      state_next = state;
      emit       = 1'b0;
      sysex_next = state.in_sysex;
      if (packet_byte == SYSEX_START) begin
         sysex_next = 1'b1;
      end else if (packet_byte == SYSEX_END) begin
         sysex_next = 1'b0;
      end

      if (starts_packet) begin
         state_next.byte_position        = POS_SECOND;
         state_next.timestamp_may_follow = 1'b0;
         state_next.dropping_packet      = {1'b0, packet_length} > CAPACITY;
      end else if (state.byte_position == POS_IDLE || state.dropping_packet) begin
         // nothing open, or packet being discarded
      end else if (state.byte_position == POS_SECOND) begin
         state_next.byte_position        = POS_LATER;
         state_next.timestamp_may_follow = 1'b0;
         emit                            = !top_set;
      end else if (state.timestamp_may_follow && top_set) begin
         state_next.timestamp_may_follow = 1'b0;
      end else begin
         state_next.in_sysex             = sysex_next;
         state_next.timestamp_may_follow = !sysex_next;
         emit                            = 1'b1;
      end
   end

endmodule

// File: sv/ble_midi_packet_deframer_unit.sv
`timescale 1ns / 1ps
// BLE-MIDI receive deframer, top level.
// Depends on bmd_pkg, bmd_stream_if and bmd_deframe_core.
//
// Usage:
//   req_port carries one raw BLE packet byte per word, with starts_packet set
//   on the header byte and packet_length giving that packet's byte count.
//   rsp_port carries the MIDI bytes left once header and timestamps are gone;
//   an input word gives zero or one output word.
//   Each accepted word sits in the input register until the result register is
//   free, is then decided, and its MIDI byte, if any, is offered from there.
//   Throughput: one word per clock while rsp_port does not stall, set by the
//   single per-byte flag update between the input and result registers.
//   Packets longer than PACKET_CAPACITY are discarded up to the next header.
//   Reset (synchronous) empties both registers and clears the packet
//   position, timestamp, SysEx and discard flags.
//   A stall on rsp_port holds the result; the input register still takes a
//   word, and req_port.ready falls only once both registers are full.
module ble_midi_packet_deframer_unit #(
   parameter int PACKET_CAPACITY = bmd_pkg::PACKET_CAPACITY_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   bmd_req_if.sink   req_port,
   bmd_rsp_if.source rsp_port
);
   import bmd_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_start_ff;
   logic [LEN_W-1:0]  in_len_ff;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff;

   state_type st_ff, st_in, st_next;
   logic      emit;
   logic      out_free, advance, req_take;

   assign out_free = !out_valid_ff || rsp_port.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_take = req_port.valid && req_port.ready;

   assign req_port.ready  = !in_valid_ff || out_free;
   assign rsp_port.valid  = out_valid_ff;
   assign rsp_port.midi_byte = out_byte_ff;

   bmd_deframe_core #(
      .PACKET_CAPACITY (PACKET_CAPACITY)
   ) u_core (
      .state         (st_ff),
      .packet_byte   (in_byte_ff),
      .starts_packet (in_start_ff),
      .packet_length (in_len_ff),
      .state_next    (st_next),
      .emit          (emit)
   );

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      st_in        = advance ? st_next : st_ff;
      out_valid_in = advance ? emit : (out_valid_ff && !rsp_port.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         st_ff        <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_port.packet_byte;
         in_start_ff <= req_port.starts_packet;
         in_len_ff   <= req_port.packet_length;
      end
      if (advance && emit) begin
         out_byte_ff <= in_byte_ff;
      end
   end

   // a header always leaves the next byte as the second of its packet
   a_header_opens: assert property (@(posedge clock) disable iff (reset)
      advance && in_start_ff |=> st_ff.byte_position == POS_SECOND)
      else $error("header did not open a packet");

   // nothing is passed on from a discarded or unopened packet
   a_no_emit_dropped: assert property (@(posedge clock) disable iff (reset)
      advance && emit |-> in_start_ff == 1'b0 && !st_ff.dropping_packet
                          && st_ff.byte_position != POS_IDLE)
      else $error("byte passed on outside an accepted packet");

   // timestamps are only expected outside a SysEx
   a_ts_outside_sysex: assert property (@(posedge clock) disable iff (reset)
      !(st_ff.timestamp_may_follow && st_ff.in_sysex))
      else $error("timestamp armed inside SysEx");

   // a stalled result stays put until taken
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_port.ready |=> out_valid_ff && $stable(out_byte_ff))
      else $error("result lost under stall");

endmodule

// File: dv/tb_ble_midi_packet_deframer_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for ble_midi_packet_deframer_unit: packet bytes in, MIDI bytes out.
// Depends on bmd_pkg, bmd_stream_if and the deframer RTL.
module tb_ble_midi_packet_deframer_unit;
   import bmd_pkg::*;

   localparam int CAPACITY       = PACKET_CAPACITY_DEFAULT;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int LIMIT_CYCLES   = 400000;

   // Tracks the deframer flags and the MIDI bytes still owed by the block.
   class deframe_tracker;
      state_type   flags;
      logic [7:0]  pending_midi[$];
      int unsigned errors;

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      function int pending_count();
         return pending_midi.size();
      endfunction

      function void note_packet_byte(logic [7:0] b, logic start, logic [9:0] len);
         if (start) begin
            flags.byte_position        = POS_SECOND;
            flags.timestamp_may_follow = 1'b0;
            flags.dropping_packet      = (len > CAPACITY);
            return;
         end
         if (flags.byte_position == POS_IDLE || flags.dropping_packet)
            return;
         if (flags.byte_position == POS_SECOND) begin
            flags.byte_position        = POS_LATER;
            flags.timestamp_may_follow = 1'b0;
            if (!b[TOP_BIT])
               pending_midi.push_back(b);
            return;
         end
         // top-bit byte right after a passed-on byte outside SysEx is a timestamp
         if (flags.timestamp_may_follow && b[TOP_BIT]) begin
            flags.timestamp_may_follow = 1'b0;
            return;
         end
         if (b == SYSEX_START)
            flags.in_sysex = 1'b1;
         else if (b == SYSEX_END)
            flags.in_sysex = 1'b0;
         flags.timestamp_may_follow = !flags.in_sysex;
         pending_midi.push_back(b);
      endfunction

      task check_midi_byte(logic [7:0] got);
         logic [7:0] want;
         if (pending_midi.size() == 0) begin
            report($sformatf("midi byte %02h with nothing expected", got));
            return;
         end
         want = pending_midi.pop_front();
         if (got !== want)
            report($sformatf("midi byte %02h, expected %02h", got, want));
      endtask
   endclass

   logic clock;
   logic reset;
   logic rsp_hold;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   words_sent;
   int unsigned cycle_count;
   event holdoff_go;
   deframe_tracker tracker;

   bmd_req_if req_bus ();
   bmd_rsp_if rsp_bus ();

   ble_midi_packet_deframer_unit #(
      .PACKET_CAPACITY(CAPACITY)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_midi_byte(rsp_bus.midi_byte);
   end

   // receiver: random stalls, plus the long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= !reset && !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      rsp_hold = 1'b0;
      forever begin
         @(holdoff_go);
         rsp_hold = 1'b1;
         repeat (HOLDOFF_CYCLES) @(posedge clock);
         rsp_hold = 1'b0;
      end
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input logic [7:0] b, input logic start, input logic [9:0] len);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.packet_byte   <= b;
      req_bus.starts_packet <= start;
      req_bus.packet_length <= len;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_packet_byte(b, start, len);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (tracker.pending_count() != 0)
         @(negedge clock);
   endtask

   function automatic logic [7:0] timestamp_byte();
      return 8'h80 | 8'($urandom_range(0, 127));
   endfunction

   task automatic send_wellformed_packet();
      logic [7:0] body[$];
      logic [9:0] len;
      int         n;
      if ($urandom_range(0, 9) == 0)
         body.push_back(8'($urandom_range(0, 127)));
      else
         body.push_back(timestamp_byte());
      repeat ($urandom_range(1, 5)) begin
         case ($urandom_range(0, 9))
            6: begin
               // running status
               repeat ($urandom_range(1, 2)) body.push_back(8'($urandom_range(0, 127)));
            end
            7: begin
               body.push_back(timestamp_byte());
               body.push_back(SYSEX_START);
               repeat ($urandom_range(0, 4)) body.push_back(8'($urandom_range(0, 127)));
            end
            8: begin
               body.push_back(timestamp_byte());
               body.push_back(SYSEX_END);
            end
            9: begin
               body.push_back(timestamp_byte());
               body.push_back(8'hF8 + 8'($urandom_range(0, 7)));
            end
            default: begin
               if ($urandom_range(0, 3) != 0)
                  body.push_back(timestamp_byte());
               body.push_back(8'h80 + 8'($urandom_range(0, 8'h6F)));
               repeat ($urandom_range(1, 2)) body.push_back(8'($urandom_range(0, 127)));
            end
         endcase
      end
      n = body.size();
      len = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, CAPACITY)) : 10'(n + 1);
      send_word(8'h80 | 8'($urandom_range(0, 63)), 1'b1, len);
      foreach (body[i])
         send_word(body[i], 1'b0, 10'($urandom_range(0, 1023)));
   endtask

   task automatic send_oversized_packet();
      logic [9:0] len;
      len = ($urandom_range(0, 3) == 0) ? 10'(CAPACITY + 1)
                                        : 10'($urandom_range(CAPACITY + 1, 1023));
      send_word(8'($urandom_range(0, 255)), 1'b1, len);
      repeat ($urandom_range(1, 8)) begin
         if ($urandom_range(0, 4) == 0)
            send_word(SYSEX_START, 1'b0, 10'($urandom_range(0, 1023)));
         else
            send_word(8'($urandom_range(0, 255)), 1'b0, 10'($urandom_range(0, 1023)));
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 6))
         send_word(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                   10'($urandom_range(0, 1023)));
   endtask

   task automatic run_random(input int words_end, input int holdoff_at);
      int pick;
      while (words_sent < words_end) begin
         if (holdoff_at >= 0 && words_sent >= holdoff_at) begin
            -> holdoff_go;
            holdoff_at = -1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 78)
            send_wellformed_packet();
         else if (pick < 88)
            send_oversized_packet();
         else if (pick < 98)
            send_noise();
         else
            wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      tracker               = new;
      tracker.flags         = '0;
      clock                 = 1'b0;
      reset                 = 1'b1;
      cycle_count           = 0;
      words_sent            = 0;
      send_idle_pct         = 28;
      recv_idle_pct         = 51;
      req_bus.valid         = 1'b0;
      req_bus.packet_byte   = '0;
      req_bus.starts_packet = 1'b0;
      req_bus.packet_length = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // bytes with no packet open
      send_word(8'h00, 1'b0, 10'd0);
      send_word(8'hFF, 1'b0, 10'h3FF);
      // packet exactly at capacity, plain second byte, later timestamp
      send_word(8'h80, 1'b1, 10'(CAPACITY));
      send_word(8'h00, 1'b0, 10'd0);
      send_word(8'hFF, 1'b0, 10'd0);
      send_word(8'h80, 1'b0, 10'd0);
      send_word(8'h7F, 1'b0, 10'd0);
      // one past capacity: all dropped, SysEx flag untouched
      send_word(8'hBF, 1'b1, 10'(CAPACITY + 1));
      send_word(8'h12, 1'b0, 10'd0);
      send_word(SYSEX_START, 1'b0, 10'd0);
      // SysEx spanning two packets, timestamps inside passed on
      send_word(8'hFF, 1'b1, 10'd3);
      send_word(8'h80, 1'b0, 10'd0);
      send_word(SYSEX_START, 1'b0, 10'd0);
      send_word(8'h85, 1'b0, 10'd0);
      send_word(8'hFF, 1'b1, 10'd5);
      send_word(8'h81, 1'b0, 10'd0);
      send_word(8'h90, 1'b0, 10'd0);
      send_word(SYSEX_END, 1'b0, 10'd0);
      send_word(8'hC3, 1'b0, 10'd0);
      send_word(8'h40, 1'b0, 10'd0);
      // length field extremes
      send_word(8'h80, 1'b1, 10'h3FF);
      send_word(8'h00, 1'b0, 10'd0);
      send_word(8'h80, 1'b1, 10'd0);
      send_word(8'h55, 1'b0, 10'd0);
      wait_drained();

      run_random(700, 300);
      send_idle_pct = 51;
      recv_idle_pct = 28;
      run_random(1400, -1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(2000, 1700);

      repeat (8) @(negedge clock);
      if (tracker.pending_count() != 0)
         tracker.report($sformatf("%0d midi bytes never arrived", tracker.pending_count()));
      if (tracker.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: ble_midi_packet_deframer_unit.f
sv/bmd_pkg.sv
sv/bmd_stream_if.sv
sv/bmd_deframe_core.sv
sv/ble_midi_packet_deframer_unit.sv
dv/tb_ble_midi_packet_deframer_unit.sv
